/* rtl/pevt_pkg.sv */
package pevt_pkg;

  localparam int IDX_W   = 10;
  localparam int LCNT_W  = 11;
  localparam int FLD_W   = 32;
  localparam int ACC_W   = 64;
  localparam int NCOMP   = 6;
  localparam int TMAG_W  = 48;
  localparam int CFG_W   = 11;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REQ_RAD     = 3'd0,
    REQ_XYZ     = 3'd1,
    REQ_CLR     = 3'd2,
    REQ_RD_GLB  = 3'd3,
    REQ_RD_ATOM = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    CFG_E_GLB  = 3'd0,
    CFG_E_ATOM = 3'd1,
    CFG_V_GLB  = 3'd2,
    CFG_V_ATOM = 3'd3,
    CFG_NEWTON = 3'd4,
    CFG_LOCAL  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              e_glb;
    logic              e_atom;
    logic              v_glb;
    logic              v_atom;
    logic              newton;
    logic [LCNT_W-1:0] local_cnt;
  } cfg_t;

  typedef enum logic [2:0] {
    MOP_NONE, MOP_T, MOP_TF, MOP_LO, MOP_HI, MOP_FIN
  } mop_t;

  typedef struct packed {
    logic       load;
    mop_t       mop;
    logic [2:0] comp;
    logic       glb_i;
    logic       glb_j;
    logic       ram_re;
    logic       ram_we;
    logic       sel_j;
    logic       clr;
    logic       out_glb;
    logic       out_atm;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_T, ST_TF, ST_LO, ST_HI, ST_FIN, ST_GLB_I, ST_GLB_J,
    ST_RD_I, ST_WR_I, ST_RD_J, ST_WR_J, ST_RD_A, ST_OUT_A, ST_OUT_G
  } state_t;

  // first and second axis of each virial component: xx yy zz xy xz yz
  function automatic logic [1:0] comp_pa(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd1, 3'd5: r = 2'd1;
      3'd2:       r = 2'd2;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] comp_pb(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd1, 3'd3:       r = 2'd1;
      3'd2, 3'd4, 3'd5: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if (!a[ACC_W-1] && !b[ACC_W-1] && s[ACC_W-1]) return ACC_MAX;
    if (a[ACC_W-1] && b[ACC_W-1] && !s[ACC_W-1]) return ACC_MIN;
    return s;
  endfunction

  // halve with ties away from zero
  function automatic logic signed [ACC_W-1:0] half_round(input logic signed [FLD_W:0] x);
    logic [FLD_W:0] m;
    logic [FLD_W:0] r;
    logic [ACC_W-1:0] e;
    m = x[FLD_W] ? (FLD_W+1)'(-x) : (FLD_W+1)'(x);
    r = (m + (FLD_W+1)'(1)) >> 1;
    e = ACC_W'(r);
    return x[FLD_W] ? -$signed(e) : $signed(e);
  endfunction

  function automatic logic [FLD_W-1:0] mag32(input logic signed [FLD_W-1:0] x);
    return x[FLD_W-1] ? FLD_W'(-x) : FLD_W'(x);
  endfunction

endpackage

/* rtl/pevt_ram.sv */
module pevt_ram #(
  parameter int W = 64,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pevt_ctrl.sv */
module pevt_ctrl
  import pevt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] req_type,
  input  stat_t      stat,
  output logic       busy,
  output cmd_t       cmd
);

  state_t     state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       rad_r, rad_nxt;

  // hold state, component count and tally kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      k_r     <= '0;
      rad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      rad_r   <= rad_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    rad_nxt   = rad_r;
    unique case (state_r)
      ST_CLEAR: if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          k_nxt   = '0;
          rad_nxt = (req_type == REQ_RAD);
          unique case (req_type)
            REQ_RAD:     state_nxt = ST_T;
            REQ_XYZ:     state_nxt = ST_LO;
            REQ_CLR:     state_nxt = ST_CLEAR;
            REQ_RD_GLB:  state_nxt = ST_OUT_G;
            REQ_RD_ATOM: state_nxt = ST_RD_A;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_T:  state_nxt = ST_TF;
      ST_TF: state_nxt = ST_LO;
      ST_LO: state_nxt = rad_r ? ST_HI : ST_FIN;
      ST_HI: state_nxt = ST_FIN;
      ST_FIN: begin
        if (k_r == 3'(NCOMP - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_GLB_I;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = rad_r ? ST_T : ST_LO;
        end
      end
      ST_GLB_I: state_nxt = ST_GLB_J;
      ST_GLB_J: state_nxt = ST_RD_I;
      ST_RD_I:  state_nxt = ST_WR_I;
      ST_WR_I:  state_nxt = ST_RD_J;
      ST_RD_J:  state_nxt = ST_WR_J;
      ST_WR_J:  state_nxt = ST_IDLE;
      ST_RD_A:  state_nxt = ST_OUT_A;
      ST_OUT_A: state_nxt = ST_IDLE;
      ST_OUT_G: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd      = '0;
    cmd.mop  = MOP_NONE;
    cmd.comp = k_r;
    busy     = (state_r != ST_IDLE);
    unique case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE:  cmd.load = start;
      ST_T:     cmd.mop = MOP_T;
      ST_TF:    cmd.mop = MOP_TF;
      ST_LO:    cmd.mop = MOP_LO;
      ST_HI:    cmd.mop = MOP_HI;
      ST_FIN:   cmd.mop = MOP_FIN;
      ST_GLB_I: cmd.glb_i = 1'b1;
      ST_GLB_J: cmd.glb_j = 1'b1;
      ST_RD_I:  cmd.ram_re = 1'b1;
      ST_WR_I:  cmd.ram_we = 1'b1;
      ST_RD_J: begin
        cmd.ram_re = 1'b1;
        cmd.sel_j  = 1'b1;
      end
      ST_WR_J: begin
        cmd.ram_we = 1'b1;
        cmd.sel_j  = 1'b1;
      end
      ST_RD_A:  cmd.ram_re = 1'b1;
      ST_OUT_A: cmd.out_atm = 1'b1;
      ST_OUT_G: cmd.out_glb = 1'b1;
      default:  cmd.mop = MOP_NONE;
    endcase
  end

endmodule

/* rtl/pevt_dp.sv */
module pevt_dp
  import pevt_pkg::*;
#(
  parameter int ATOMS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  cfg_t                       cfg,
  input  logic [2:0]                 req_type,
  input  logic [IDX_W-1:0]           atom_i,
  input  logic [IDX_W-1:0]           atom_j,
  input  logic signed [FLD_W-1:0]    energy_vdw,
  input  logic signed [FLD_W-1:0]    energy_coul,
  input  logic signed [FLD_W-1:0]    force_radial,
  input  logic signed [FLD_W-1:0]    force_x,
  input  logic signed [FLD_W-1:0]    force_y,
  input  logic signed [FLD_W-1:0]    force_z,
  input  logic signed [FLD_W-1:0]    disp_x,
  input  logic signed [FLD_W-1:0]    disp_y,
  input  logic signed [FLD_W-1:0]    disp_z,
  // per-atom memories
  output logic                       mem_re,
  output logic [$clog2(ATOMS)-1:0]   mem_raddr,
  output logic [$clog2(ATOMS)-1:0]   mem_waddr,
  output logic                       me_we,
  output logic [ACC_W-1:0]           me_wdata,
  input  logic [ACC_W-1:0]           me_rdata,
  output logic                       mv_we,
  output logic [NCOMP*ACC_W-1:0]     mv_wdata,
  input  logic [NCOMP*ACC_W-1:0]     mv_rdata,
  // results
  output logic                       out_valid,
  output logic signed [ACC_W-1:0]    out_a,
  output logic signed [ACC_W-1:0]    out_b,
  output logic signed [ACC_W-1:0]    out_vir [NCOMP]
);

  localparam int AW = $clog2(ATOMS);
  localparam int XW = (AW > IDX_W) ? AW : IDX_W;
  localparam int MW = IDX_W + 18;

  // reduce an atom index into the store range
  function automatic logic [IDX_W-1:0] idx_mod(input logic [IDX_W-1:0] x);
    logic [MW-1:0] r;
    r = MW'(x);
    if (ATOMS < (1 << IDX_W)) begin
      for (int s = IDX_W - 1; s >= 0; s--) begin
        if (r >= (MW'(ATOMS) << s)) r = r - (MW'(ATOMS) << s);
      end
    end
    return r[IDX_W-1:0];
  endfunction

  // latched request
  logic                    rad_r;
  logic [IDX_W-1:0]        ri_r, rj_r;
  logic signed [FLD_W-1:0] ev_r, ec_r, fr_r;
  logic signed [FLD_W-1:0] f_r [3];
  logic signed [FLD_W-1:0] d_r [3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rad_r  <= (req_type == REQ_RAD);
      ri_r   <= atom_i;
      rj_r   <= atom_j;
      ev_r   <= energy_vdw;
      ec_r   <= energy_coul;
      fr_r   <= force_radial;
      f_r[0] <= force_x;
      f_r[1] <= force_y;
      f_r[2] <= force_z;
      d_r[0] <= disp_x;
      d_r[1] <= disp_y;
      d_r[2] <= disp_z;
    end
  end

  // operand selection for the shared multiplier
  logic [1:0]              pa, pb;
  logic signed [FLD_W-1:0] da, db, fb;
  logic [FLD_W-1:0]        mul_a, mul_b;
  logic [2*FLD_W-1:0]      prod;
  logic [2*FLD_W-1:0]      lo_r, hi_r;
  logic [TMAG_W-1:0]       t_r;
  logic                    sgn_r;
  logic [ACC_W-1:0]        rnd16, rnd17;
  logic signed [ACC_W-1:0] v_r [NCOMP];
  logic signed [ACC_W-1:0] h_r [NCOMP];

  assign pa = comp_pa(cmd.comp);
  assign pb = comp_pb(cmd.comp);
  assign da = d_r[pa];
  assign db = d_r[pb];
  assign fb = f_r[pb];

  always_comb begin
    mul_a = mag32(da);
    mul_b = mag32(db);
    case (cmd.mop)
      MOP_LO: begin
        mul_a = rad_r ? t_r[FLD_W-1:0] : mag32(da);
        mul_b = rad_r ? mag32(fr_r) : mag32(fb);
      end
      MOP_HI: begin
        mul_a = FLD_W'(t_r[TMAG_W-1:FLD_W]);
        mul_b = mag32(fr_r);
      end
      default: begin
        mul_a = mag32(da);
        mul_b = mag32(db);
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign rnd16 = (hi_r << 16) + ((lo_r + 64'd32768) >> 16);
  assign rnd17 = (hi_r << 15) + ((lo_r + 64'd65536) >> 17);

  // step the virial product sequence
  always_ff @(posedge clk) begin
    case (cmd.mop)
      MOP_T: begin
        lo_r  <= prod;
        sgn_r <= da[FLD_W-1] ^ db[FLD_W-1];
      end
      MOP_TF: t_r <= TMAG_W'((lo_r + 64'd32768) >> 16);
      MOP_LO: begin
        lo_r <= prod;
        if (rad_r) begin
          sgn_r <= sgn_r ^ fr_r[FLD_W-1];
        end else begin
          hi_r  <= '0;
          sgn_r <= da[FLD_W-1] ^ fb[FLD_W-1];
        end
      end
      MOP_HI: hi_r <= prod;
      MOP_FIN: begin
        v_r[cmd.comp] <= sgn_r ? -$signed(rnd16) : $signed(rnd16);
        h_r[cmd.comp] <= sgn_r ? -$signed(rnd17) : $signed(rnd17);
      end
      default: ;
    endcase
  end

  // energy shares and locality
  logic signed [ACC_W-1:0] ev64, ec64, hv, hc, hp;
  logic                    iloc, jloc, icred, jcred;

  assign ev64  = ACC_W'(ev_r);
  assign ec64  = ACC_W'(ec_r);
  assign hv    = half_round({ev_r[FLD_W-1], ev_r});
  assign hc    = half_round({ec_r[FLD_W-1], ec_r});
  assign hp    = half_round({ev_r[FLD_W-1], ev_r} + {ec_r[FLD_W-1], ec_r});
  assign iloc  = {1'b0, ri_r} < cfg.local_cnt;
  assign jloc  = {1'b0, rj_r} < cfg.local_cnt;
  assign icred = cfg.newton | iloc;
  assign jcred = cfg.newton | jloc;

  // global sums: first share, then second share when newton is off
  logic signed [ACC_W-1:0] gvdw_r, gcoul_r;
  logic signed [ACC_W-1:0] gvir_r [NCOMP];
  logic                    g_en, g_full;

  assign g_full = cmd.glb_i & cfg.newton;
  assign g_en   = (cmd.glb_i & icred) | (cmd.glb_j & ~cfg.newton & jloc);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      gvdw_r  <= '0;
      gcoul_r <= '0;
      for (int k = 0; k < NCOMP; k++) gvir_r[k] <= '0;
    end else if (g_en) begin
      if (cfg.e_glb) begin
        gvdw_r  <= sat_add(gvdw_r, g_full ? ev64 : hv);
        gcoul_r <= sat_add(gcoul_r, g_full ? ec64 : hc);
      end
      if (cfg.v_glb) begin
        for (int k = 0; k < NCOMP; k++) begin
          gvir_r[k] <= sat_add(gvir_r[k], g_full ? v_r[k] : h_r[k]);
        end
      end
    end
  end

  // per-atom read-modify-write and clearing sweep
  logic [XW-1:0] ai_x, aj_x;
  logic [AW-1:0] ai, aj, asel, cnt_r;
  logic          cred;

  assign ai_x = XW'(idx_mod(ri_r));
  assign aj_x = XW'(idx_mod(rj_r));
  assign ai   = ai_x[AW-1:0];
  assign aj   = aj_x[AW-1:0];
  assign asel = cmd.sel_j ? aj : ai;
  assign cred = cmd.sel_j ? jcred : icred;

  assign stat.clr_last = (cnt_r == AW'(ATOMS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.clr) begin
      cnt_r <= stat.clr_last ? '0 : cnt_r + AW'(1);
    end
  end

  assign mem_re    = cmd.ram_re;
  assign mem_raddr = asel;
  assign mem_waddr = cmd.clr ? cnt_r : asel;
  assign me_we     = cmd.clr | (cmd.ram_we & cfg.e_atom & cred);
  assign mv_we     = cmd.clr | (cmd.ram_we & cfg.v_atom & cred);
  assign me_wdata  = cmd.clr ? '0 : sat_add(me_rdata, hp);

  always_comb begin
    for (int k = 0; k < NCOMP; k++) begin
      mv_wdata[k*ACC_W +: ACC_W] = cmd.clr ? '0 :
                                   sat_add(mv_rdata[k*ACC_W +: ACC_W], h_r[k]);
    end
  end

  // result register: one strobe beat per read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.out_glb | cmd.out_atm;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_glb) begin
      out_a <= gvdw_r;
      out_b <= gcoul_r;
      for (int k = 0; k < NCOMP; k++) out_vir[k] <= gvir_r[k];
    end else if (cmd.out_atm) begin
      out_a <= me_rdata;
      out_b <= '0;
      for (int k = 0; k < NCOMP; k++) out_vir[k] <= mv_rdata[k*ACC_W +: ACC_W];
    end
  end

endmodule

/* rtl/pair_energy_virial_tally_top.sv */
// Pair energy and virial tally. One request is taken per start beat while busy
// is low; a read returns one beat on out_valid that the receiver must take at
// once. After reset the per-atom stores are swept to zero with busy high;
// configuration writes are taken at any time. Tally time is set by the one
// shared 32x32 multiplier that forms each of the six virial terms in turn
// (steps T, TF, LO, HI and FIN for radial, LO and FIN for xyz) and by the
// read-modify-write of each atom row through the single read and write port
// of the per-atom memories.
module pair_energy_virial_tally_top
  import pevt_pkg::*;
#(
  parameter int ATOMS = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_req_type,
  input  logic [IDX_W-1:0]        in_atom_i,
  input  logic [IDX_W-1:0]        in_atom_j,
  input  logic signed [FLD_W-1:0] in_energy_vdw,
  input  logic signed [FLD_W-1:0] in_energy_coul,
  input  logic signed [FLD_W-1:0] in_force_radial,
  input  logic signed [FLD_W-1:0] in_force_x,
  input  logic signed [FLD_W-1:0] in_force_y,
  input  logic signed [FLD_W-1:0] in_force_z,
  input  logic signed [FLD_W-1:0] in_disp_x,
  input  logic signed [FLD_W-1:0] in_disp_y,
  input  logic signed [FLD_W-1:0] in_disp_z,
  output logic                    out_valid,
  output logic signed [ACC_W-1:0] out_sum_energy_a,
  output logic signed [ACC_W-1:0] out_sum_energy_b,
  output logic signed [ACC_W-1:0] out_vir_xx,
  output logic signed [ACC_W-1:0] out_vir_yy,
  output logic signed [ACC_W-1:0] out_vir_zz,
  output logic signed [ACC_W-1:0] out_vir_xy,
  output logic signed [ACC_W-1:0] out_vir_xz,
  output logic signed [ACC_W-1:0] out_vir_yz,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int AW = $clog2(ATOMS);

  cfg_t  cfg_r;
  cmd_t  cmd;
  stat_t stat;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{e_glb: 1'b0, e_atom: 1'b0, v_glb: 1'b0, v_atom: 1'b0,
                 newton: 1'b1, local_cnt: '0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_E_GLB:  cfg_r.e_glb     <= cfg_data[0];
        CFG_E_ATOM: cfg_r.e_atom    <= cfg_data[0];
        CFG_V_GLB:  cfg_r.v_glb     <= cfg_data[0];
        CFG_V_ATOM: cfg_r.v_atom    <= cfg_data[0];
        CFG_NEWTON: cfg_r.newton    <= cfg_data[0];
        CFG_LOCAL:  cfg_r.local_cnt <= cfg_data[LCNT_W-1:0];
        default:    ;
      endcase
    end
  end

  logic                   mem_re, me_we, mv_we;
  logic [AW-1:0]          mem_raddr, mem_waddr;
  logic [ACC_W-1:0]       me_wdata, me_rdata;
  logic [NCOMP*ACC_W-1:0] mv_wdata, mv_rdata;
  logic signed [ACC_W-1:0] out_vir [NCOMP];

  pevt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  pevt_dp #(.ATOMS(ATOMS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg_r),
    .req_type     (in_req_type),
    .atom_i       (in_atom_i),
    .atom_j       (in_atom_j),
    .energy_vdw   (in_energy_vdw),
    .energy_coul  (in_energy_coul),
    .force_radial (in_force_radial),
    .force_x      (in_force_x),
    .force_y      (in_force_y),
    .force_z      (in_force_z),
    .disp_x       (in_disp_x),
    .disp_y       (in_disp_y),
    .disp_z       (in_disp_z),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_waddr    (mem_waddr),
    .me_we        (me_we),
    .me_wdata     (me_wdata),
    .me_rdata     (me_rdata),
    .mv_we        (mv_we),
    .mv_wdata     (mv_wdata),
    .mv_rdata     (mv_rdata),
    .out_valid    (out_valid),
    .out_a        (out_sum_energy_a),
    .out_b        (out_sum_energy_b),
    .out_vir      (out_vir)
  );

  // per-atom energy store
  pevt_ram #(.W(ACC_W), .D(ATOMS)) u_ram_e (
    .clk   (clk),
    .we    (me_we),
    .waddr (mem_waddr),
    .wdata (me_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (me_rdata)
  );

  // per-atom virial store, one row of six components per atom
  pevt_ram #(.W(NCOMP*ACC_W), .D(ATOMS)) u_ram_v (
    .clk   (clk),
    .we    (mv_we),
    .waddr (mem_waddr),
    .wdata (mv_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mv_rdata)
  );

  assign out_vir_xx = out_vir[0];
  assign out_vir_yy = out_vir[1];
  assign out_vir_zz = out_vir[2];
  assign out_vir_xy = out_vir[3];
  assign out_vir_xz = out_vir[4];
  assign out_vir_yz = out_vir[5];

  // a result beat never repeats
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  // a result is shown only once the request has finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // a tally keeps the block busy
  a_tally_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_RAD || in_req_type == REQ_XYZ)) |=> busy)
    else $error("tally accepted without going busy");

  // no memory write while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !(me_we || mv_we))
    else $error("memory write while idle");

endmodule
